>>> sv/eddb_pkg.sv
// ----------------------------------------------------------------------------
// eddb_pkg
// Types and constants shared by the equi-depth bucket builder.
// ----------------------------------------------------------------------------
package eddb_pkg;

   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned WEIGHT_W = 32;
   localparam int unsigned COUNT_W  = 48;
   localparam int unsigned LIMIT_W  = 9;
   localparam int unsigned PROD_W   = COUNT_W + LIMIT_W;

   // largest bucket count the builder will honor
   localparam logic [LIMIT_W-1:0] MAX_PARTS     = 9'd256;
   localparam logic [LIMIT_W-1:0] PART_LIMIT_RST = 9'd64;
   localparam logic [COUNT_W-1:0] COUNT_SAT     = '1;

   typedef enum logic [1:0] {
      CSR_TOTAL_COUNT    = 2'd0,
      CSR_DISTINCT_COUNT = 2'd1,
      CSR_PART_LIMIT     = 2'd2,
      CSR_MAX_VALUE      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] lo_bound;
      logic signed [VALUE_W-1:0] hi_bound;
      logic [COUNT_W-1:0]        bucket_count;
      logic                      last_bucket;
      logic                      empty_marker;
   } rsp_item_type;

   // results produced by one item, packed from item0 upward
   typedef struct packed {
      logic [1:0]   num;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

>>> sv/eddb_if.sv
// ----------------------------------------------------------------------------
// eddb interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface eddb_req_if;
   import eddb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic [WEIGHT_W-1:0]       weight;
   logic                      final_item;

   modport source (output valid, value, weight, final_item, input ready);
   modport sink   (input valid, value, weight, final_item, output ready);
endinterface

interface eddb_rsp_if;
   import eddb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] lo_bound;
   logic signed [VALUE_W-1:0] hi_bound;
   logic [COUNT_W-1:0]        bucket_count;
   logic                      last_bucket;
   logic                      empty_marker;

   modport source (output valid, lo_bound, hi_bound, bucket_count, last_bucket,
                   empty_marker, input ready);
   modport sink   (input valid, lo_bound, hi_bound, bucket_count, last_bucket,
                   empty_marker, output ready);
endinterface

interface eddb_csr_if;
   import eddb_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [63:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/eddb_core.sv
// ----------------------------------------------------------------------------
// eddb_core
// Input register, run state and the per-item bucket closing logic.
// ----------------------------------------------------------------------------
module eddb_core (
   input  logic              clock,
   input  logic              reset,
   eddb_req_if.sink          req_bus,
   eddb_csr_if.sink          csr_bus,
   input  logic              rsp_space,
   output eddb_pkg::push_type push
);
   import eddb_pkg::*;

   // configuration
   logic [COUNT_W-1:0]        total_count_ff, total_count_in;
   logic [COUNT_W-1:0]        distinct_count_ff, distinct_count_in;
   logic [LIMIT_W-1:0]        part_limit_ff, part_limit_in;
   logic signed [VALUE_W-1:0] max_value_ff, max_value_in;

   // input register
   logic                      stg_valid_ff, stg_valid_in;
   logic signed [VALUE_W-1:0] stg_value_ff, stg_value_in;
   logic [WEIGHT_W-1:0]       stg_weight_ff, stg_weight_in;
   logic                      stg_final_ff, stg_final_in;

   // run state
   logic [COUNT_W-1:0]        running_sum_ff, running_sum_in;
   logic signed [VALUE_W-1:0] open_lo_ff, open_lo_in;
   logic                      open_lo_valid_ff, open_lo_valid_in;
   logic [LIMIT_W-1:0]        closed_buckets_ff, closed_buckets_in;
   logic signed [VALUE_W-1:0] held_lo_ff, held_lo_in;
   logic signed [VALUE_W-1:0] held_hi_ff, held_hi_in;
   logic [COUNT_W-1:0]        held_count_ff, held_count_in;
   logic                      held_valid_ff, held_valid_in;

   logic advance;
   logic req_accept;

   assign advance      = stg_valid_ff && rsp_space;
   assign req_bus.ready = !stg_valid_ff || advance;
   assign req_accept   = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      total_count_in    = total_count_ff;
      distinct_count_in = distinct_count_ff;
      part_limit_in     = part_limit_ff;
      max_value_in      = max_value_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_TOTAL_COUNT:    total_count_in    = csr_bus.data[COUNT_W-1:0];
            CSR_DISTINCT_COUNT: distinct_count_in = csr_bus.data[COUNT_W-1:0];
            CSR_PART_LIMIT:     part_limit_in     = csr_bus.data[LIMIT_W-1:0];
            CSR_MAX_VALUE:      max_value_in      = csr_bus.data;
         endcase
      end
   end

   always_comb begin
      stg_valid_in  = req_accept || (stg_valid_ff && !advance);
      stg_value_in  = stg_value_ff;
      stg_weight_in = stg_weight_ff;
      stg_final_in  = stg_final_ff;
      if (req_accept) begin
         stg_value_in  = req_bus.value;
         stg_weight_in = req_bus.weight;
         stg_final_in  = req_bus.final_item;
      end
   end

   // bucket logic on the registered item
   always_comb begin
      logic [LIMIT_W-1:0]        limit;
      logic                      active;
      logic [COUNT_W:0]          sum_add;
      logic [COUNT_W-1:0]        sum_sat;
      logic [PROD_W-1:0]         prod;
      logic                      close;
      logic signed [VALUE_W-1:0] olo;
      logic [COUNT_W-1:0]        sum1;
      logic signed [VALUE_W-1:0] olo1;
      logic                      olv1;
      logic [LIMIT_W-1:0]        closed1;
      logic signed [VALUE_W-1:0] hlo1;
      logic signed [VALUE_W-1:0] hhi1;
      logic [COUNT_W-1:0]        hcnt1;
      logic                      hv1;
      logic                      tail;
      rsp_item_type              close_item;
      rsp_item_type              fa;
      rsp_item_type              fb;
      logic                      close_v;
      logic                      fa_v;
      logic                      fb_v;
      rsp_item_type              tail_item;

      if (part_limit_ff == '0) begin
         limit = LIMIT_W'(1);
      end else if (part_limit_ff > MAX_PARTS) begin
         limit = MAX_PARTS;
      end else begin
         limit = part_limit_ff;
      end

      active  = closed_buckets_ff < limit;
      sum_add = {1'b0, running_sum_ff} + {{(COUNT_W+1-WEIGHT_W){1'b0}}, stg_weight_ff};
      sum_sat = sum_add[COUNT_W] ? COUNT_SAT : sum_add[COUNT_W-1:0];
      prod    = {{LIMIT_W{1'b0}}, sum_sat} * {{COUNT_W{1'b0}}, limit};
      olo     = open_lo_valid_ff ? open_lo_ff : stg_value_ff;

      if (distinct_count_ff <= {{(COUNT_W-LIMIT_W){1'b0}}, limit}) begin
         close = active && (sum_sat != '0);
      end else begin
         close = active && (prod >= {{LIMIT_W{1'b0}}, total_count_ff});
      end

      // state after the item, before any end-of-run handling
      sum1    = running_sum_ff;
      olo1    = open_lo_ff;
      olv1    = open_lo_valid_ff;
      closed1 = closed_buckets_ff;
      hlo1    = held_lo_ff;
      hhi1    = held_hi_ff;
      hcnt1   = held_count_ff;
      hv1     = held_valid_ff;
      if (active) begin
         sum1 = close ? '0 : sum_sat;
         olo1 = olo;
         olv1 = !close;
         if (close) begin
            closed1 = closed_buckets_ff + LIMIT_W'(1);
            hlo1    = olo;
            hhi1    = stg_value_ff;
            hcnt1   = sum_sat;
            hv1     = 1'b1;
         end
      end

      // a closing releases the previously held bucket
      close_v    = close && held_valid_ff;
      close_item = '{lo_bound: held_lo_ff, hi_bound: held_hi_ff,
                     bucket_count: held_count_ff, last_bucket: 1'b0,
                     empty_marker: 1'b0};

      tail      = sum1 != '0;
      tail_item = '{lo_bound: olo1, hi_bound: max_value_ff, bucket_count: sum1,
                    last_bucket: 1'b1, empty_marker: 1'b0};
      fa_v = 1'b0;
      fb_v = 1'b0;
      fa   = tail_item;
      fb   = tail_item;
      if (stg_final_ff) begin
         fa_v = 1'b1;
         if (closed1 >= limit && hv1) begin
            fa = '{lo_bound: hlo1, hi_bound: max_value_ff, bucket_count: hcnt1,
                   last_bucket: 1'b1, empty_marker: 1'b0};
         end else if (hv1) begin
            fa   = '{lo_bound: hlo1, hi_bound: hhi1, bucket_count: hcnt1,
                     last_bucket: !tail, empty_marker: 1'b0};
            fb_v = tail;
         end else if (!tail) begin
            fa = '{lo_bound: '0, hi_bound: '0, bucket_count: '0,
                   last_bucket: 1'b1, empty_marker: 1'b1};
         end
      end

      // pack results; a closing and a tail never occur together
      push.num   = 2'(close_v) + 2'(fa_v) + 2'(fb_v);
      push.item0 = close_v ? close_item : fa;
      push.item1 = close_v ? fa : fb;
      if (!advance) begin
         push.num = '0;
      end

      running_sum_in    = running_sum_ff;
      open_lo_in        = open_lo_ff;
      open_lo_valid_in  = open_lo_valid_ff;
      closed_buckets_in = closed_buckets_ff;
      held_lo_in        = held_lo_ff;
      held_hi_in        = held_hi_ff;
      held_count_in     = held_count_ff;
      held_valid_in     = held_valid_ff;
      if (advance) begin
         if (stg_final_ff) begin
            running_sum_in    = '0;
            open_lo_in        = '0;
            open_lo_valid_in  = 1'b0;
            closed_buckets_in = '0;
            held_lo_in        = '0;
            held_hi_in        = '0;
            held_count_in     = '0;
            held_valid_in     = 1'b0;
         end else begin
            running_sum_in    = sum1;
            open_lo_in        = olo1;
            open_lo_valid_in  = olv1;
            closed_buckets_in = closed1;
            held_lo_in        = hlo1;
            held_hi_in        = hhi1;
            held_count_in     = hcnt1;
            held_valid_in     = hv1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_count_ff    <= '0;
         distinct_count_ff <= '0;
         part_limit_ff     <= PART_LIMIT_RST;
         max_value_ff      <= '0;
         stg_valid_ff      <= 1'b0;
         running_sum_ff    <= '0;
         open_lo_ff        <= '0;
         open_lo_valid_ff  <= 1'b0;
         closed_buckets_ff <= '0;
         held_lo_ff        <= '0;
         held_hi_ff        <= '0;
         held_count_ff     <= '0;
         held_valid_ff     <= 1'b0;
      end else begin
         total_count_ff    <= total_count_in;
         distinct_count_ff <= distinct_count_in;
         part_limit_ff     <= part_limit_in;
         max_value_ff      <= max_value_in;
         stg_valid_ff      <= stg_valid_in;
         running_sum_ff    <= running_sum_in;
         open_lo_ff        <= open_lo_in;
         open_lo_valid_ff  <= open_lo_valid_in;
         closed_buckets_ff <= closed_buckets_in;
         held_lo_ff        <= held_lo_in;
         held_hi_ff        <= held_hi_in;
         held_count_ff     <= held_count_in;
         held_valid_ff     <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_value_ff  <= stg_value_in;
      stg_weight_ff <= stg_weight_in;
      stg_final_ff  <= stg_final_in;
   end

endmodule

>>> sv/eddb_rsp_fifo.sv
// ----------------------------------------------------------------------------
// eddb_rsp_fifo
// Result queue: takes up to two items per cycle, hands out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module eddb_rsp_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  eddb_pkg::push_type push,
   output logic               space,
   eddb_rsp_if.source         rsp_bus
);
   import eddb_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] SPACE_MAX = CNT_W'(DEPTH - 2);

   rsp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_nx;
   logic             pop;
   rsp_item_type     head;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_ptr_nx = next_ptr(wr_ptr_ff);
   assign pop       = rsp_bus.valid && rsp_bus.ready;
   // room for the two results one item may bring
   assign space     = count_ff <= SPACE_MAX;

   always_comb begin
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);
      case (push.num)
         2'd1:    wr_ptr_in = wr_ptr_nx;
         2'd2:    wr_ptr_in = next_ptr(wr_ptr_nx);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
   end

   assign head                 = mem_ff[rd_ptr_ff];
   assign rsp_bus.valid        = count_ff != '0;
   assign rsp_bus.lo_bound     = head.lo_bound;
   assign rsp_bus.hi_bound     = head.hi_bound;
   assign rsp_bus.bucket_count = head.bucket_count;
   assign rsp_bus.last_bucket  = head.last_bucket;
   assign rsp_bus.empty_marker = head.empty_marker;

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ptr_nx] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/equi_depth_bucket_builder_top.sv
// ----------------------------------------------------------------------------
// equi_depth_bucket_builder_top: each result passes the input register, then the result queue.
// One item per cycle while results are taken as fast as they are made; a final
// item may bring two results, which the result queue absorbs, and the input
// stalls only while fewer than two queue entries are free.
// Reset clears run state and registers (part_limit to 64); no warm-up is needed.
// ----------------------------------------------------------------------------
module equi_depth_bucket_builder_top #(
   parameter int unsigned RSP_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   eddb_req_if.sink   req_bus,
   eddb_rsp_if.source rsp_bus,
   eddb_csr_if.sink   csr_bus
);
   import eddb_pkg::*;

   push_type push;
   logic     rsp_space;

   eddb_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_bus   (csr_bus),
      .rsp_space (rsp_space),
      .push      (push)
   );

   eddb_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .space   (rsp_space),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equi-depth bucket builder testbench
// Drives runs of sorted values with weights into the builder and checks every
// emitted bucket against a scoreboard. The scoreboard computes buckets from
// the register settings in effect. A short directed table comes first, then a
// run of full-size weights, then random runs under random register settings.
// Random idling is applied on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import eddb_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int SWEEP_ITEMS   = 200;
   localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type idx;
      logic [63:0]   data;
      logic [31:0]   weight;
      logic          fin;
      bit            typed;
      rsp_item_type  want;
   } script_row_type;

   typedef struct {
      bit           typed;
      rsp_item_type want;
   } item_tag_type;

   logic clock = 1'b0;
   logic reset;

   eddb_req_if req_bus ();
   eddb_rsp_if rsp_bus ();
   eddb_csr_if csr_bus ();

   equi_depth_bucket_builder_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // register mirror
   logic [COUNT_W-1:0] cfg_total;
   logic [COUNT_W-1:0] cfg_distinct;
   logic [LIMIT_W-1:0] cfg_limit;
   logic [63:0]        cfg_max;

   // run state of the bucket scoreboard
   logic [COUNT_W-1:0] run_sum;
   logic [63:0]        open_lo;
   bit                 open_ok;
   int                 closed_n;
   logic [63:0]        held_lo;
   logic [63:0]        held_hi;
   logic [COUNT_W-1:0] held_cnt;
   bit                 held_ok;

   rsp_item_type   made [2];
   rsp_item_type   expected_buckets [$];
   item_tag_type   item_tags [$];
   script_row_type script [$];

   rsp_item_type seen;
   item_tag_type tag_now;
   int           made_n;
   int           taken_items = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           hold_left = 0;
   bit           quick = 1'b0;
   bit           burst = 1'b0;

   function automatic rsp_item_type make_bucket(logic [63:0] lo, logic [63:0] hi,
                                                logic [COUNT_W-1:0] cnt,
                                                logic is_last, logic is_empty);
      rsp_item_type b;
      b.lo_bound     = lo;
      b.hi_bound     = hi;
      b.bucket_count = cnt;
      b.last_bucket  = is_last;
      b.empty_marker = is_empty;
      return b;
   endfunction

   function automatic void clear_run();
      run_sum  = '0;
      open_lo  = '0;
      open_ok  = 1'b0;
      closed_n = 0;
      held_lo  = '0;
      held_hi  = '0;
      held_cnt = '0;
      held_ok  = 1'b0;
   endfunction

   // Advance the run by one item; return how many buckets it emits into made[].
   function automatic int predict_buckets(logic [63:0] v, logic [31:0] w, logic f);
      logic [LIMIT_W-1:0] lim;
      logic [COUNT_W:0]   acc;
      logic [63:0]        prod;
      bit                 shut;
      bit                 tail;
      int                 n;
      n = 0;
      lim = cfg_limit;
      if (lim == 0) lim = 1;
      if (lim > MAX_PARTS) lim = MAX_PARTS;
      if (closed_n < lim || f) taken_items++;
      if (closed_n < lim) begin
         acc = {1'b0, run_sum} + {17'd0, w};
         run_sum = acc[COUNT_W] ? COUNT_SAT : acc[COUNT_W-1:0];
         if (!open_ok) begin
            open_lo = v;
            open_ok = 1'b1;
         end
         if (cfg_distinct <= lim) begin
            shut = (run_sum != 0);
         end else begin
            prod = {16'd0, run_sum} * {55'd0, lim};
            shut = (prod >= {16'd0, cfg_total});
         end
         if (shut) begin
            // release the previously held bucket, hold the new one
            if (held_ok) begin
               made[n] = make_bucket(held_lo, held_hi, held_cnt, 1'b0, 1'b0);
               n++;
            end
            held_lo  = open_lo;
            held_hi  = v;
            held_cnt = run_sum;
            held_ok  = 1'b1;
            run_sum  = '0;
            open_ok  = 1'b0;
            closed_n++;
         end
      end
      if (f) begin
         if (closed_n >= lim && held_ok) begin
            made[n] = make_bucket(held_lo, cfg_max, held_cnt, 1'b1, 1'b0);
            n++;
         end else begin
            tail = (run_sum != 0);
            if (held_ok) begin
               made[n] = make_bucket(held_lo, held_hi, held_cnt, !tail, 1'b0);
               n++;
            end
            if (tail) begin
               made[n] = make_bucket(open_lo, cfg_max, run_sum, 1'b1, 1'b0);
               n++;
            end
            if (n == 0) begin
               made[n] = make_bucket('0, '0, '0, 1'b1, 1'b1);
               n++;
            end
         end
         clear_run();
      end
      return n;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < 40) $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_bucket(rsp_item_type got, rsp_item_type want);
      if (got.lo_bound !== want.lo_bound)
         report_mismatch($sformatf("lo_bound %0d, want %0d", got.lo_bound, want.lo_bound));
      if (got.hi_bound !== want.hi_bound)
         report_mismatch($sformatf("hi_bound %0d, want %0d", got.hi_bound, want.hi_bound));
      if (got.bucket_count !== want.bucket_count)
         report_mismatch($sformatf("bucket_count %0d, want %0d", got.bucket_count,
                                   want.bucket_count));
      if (got.last_bucket !== want.last_bucket)
         report_mismatch($sformatf("last_bucket %b, want %b", got.last_bucket,
                                   want.last_bucket));
      if (got.empty_marker !== want.empty_marker)
         report_mismatch($sformatf("empty_marker %b, want %b", got.empty_marker,
                                   want.empty_marker));
   endtask

   // Scoreboard: results first, then the item, then register writes.
   always @(posedge clock) begin
      if (reset) begin
         cfg_total    = '0;
         cfg_distinct = '0;
         cfg_limit    = PART_LIMIT_RST;
         cfg_max      = '0;
         clear_run();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = make_bucket(rsp_bus.lo_bound, rsp_bus.hi_bound, rsp_bus.bucket_count,
                               rsp_bus.last_bucket, rsp_bus.empty_marker);
            if (expected_buckets.size() == 0)
               report_mismatch($sformatf("unexpected bucket lo=%0d hi=%0d count=%0d",
                                         seen.lo_bound, seen.hi_bound, seen.bucket_count));
            else
               check_bucket(seen, expected_buckets.pop_front());
         end
         if (req_bus.valid && req_bus.ready) begin
            made_n = predict_buckets(req_bus.value, req_bus.weight, req_bus.final_item);
            tag_now = item_tags.pop_front();
            if (tag_now.typed) begin
               expected_buckets.push_back(tag_now.want);
            end else begin
               for (int k = 0; k < made_n; k++) expected_buckets.push_back(made[k]);
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_TOTAL_COUNT:    cfg_total    = csr_bus.data[COUNT_W-1:0];
               CSR_DISTINCT_COUNT: cfg_distinct = csr_bus.data[COUNT_W-1:0];
               CSR_PART_LIMIT:     cfg_limit    = csr_bus.data[LIMIT_W-1:0];
               CSR_MAX_VALUE:      cfg_max      = csr_bus.data;
            endcase
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (quick) return ($urandom_range(0, 7) == 0) ? 1 : 0;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         hold_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp_bus.ready <= (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic drive_item(logic [63:0] v, logic [31:0] w, logic f, bit typed,
                             rsp_item_type want);
      item_tag_type t;
      int gap;
      t.typed = typed;
      t.want  = want;
      item_tags.push_back(t);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.value      <= v;
      req_bus.weight     <= w;
      req_bus.final_item <= f;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] d);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= d;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // Hold until every expected bucket is out and the pipeline has settled.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_buckets.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void add_item(logic [63:0] v, logic [31:0] w, logic f);
      script_row_type r;
      r.kind   = ROW_ITEM;
      r.idx    = CSR_TOTAL_COUNT;
      r.data   = v;
      r.weight = w;
      r.fin    = f;
      r.typed  = 1'b0;
      r.want   = '0;
      script.push_back(r);
   endfunction

   function automatic void add_typed(logic [63:0] v, logic [31:0] w, logic f,
                                     rsp_item_type want);
      add_item(v, w, f);
      script[script.size()-1].typed = 1'b1;
      script[script.size()-1].want  = want;
   endfunction

   function automatic void add_reg(csr_index_type idx, logic [63:0] d);
      add_item(d, '0, 1'b0);
      script[script.size()-1].kind = ROW_REG;
      script[script.size()-1].idx  = idx;
   endfunction

   task automatic play_script();
      script_row_type r;
      for (int i = 0; i < script.size(); i++) begin
         r = script[i];
         if (r.kind == ROW_REG) begin
            if (i == 0 || script[i-1].kind != ROW_REG) quiesce();
            write_reg(r.idx, r.data);
            if (i + 1 == script.size() || script[i+1].kind != ROW_REG)
               csr_bus.valid <= 1'b0;
         end else begin
            drive_item(r.data, r.weight, r.fin, r.typed, r.want);
         end
      end
   endtask

   // Weights of max size with no closing before the end of the run.
   task automatic saturation_sweep();
      quiesce();
      write_reg(CSR_PART_LIMIT, 64'd1);
      write_reg(CSR_TOTAL_COUNT, {16'd0, COUNT_SAT});
      write_reg(CSR_DISTINCT_COUNT, '1);
      write_reg(CSR_MAX_VALUE, {$urandom, $urandom});
      csr_bus.valid <= 1'b0;
      quick = 1'b1;
      for (int k = 0; k < SWEEP_ITEMS; k++)
         drive_item(64'(k), '1, k == SWEEP_ITEMS - 1, 1'b0, '0);
      quick = 1'b0;
   endtask

   task automatic run_phase();
      logic [31:0]        wts [$];
      logic [31:0]        w;
      logic [COUNT_W-1:0] wsum;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] distinct;
      logic [LIMIT_W-1:0] lim;
      logic [63:0]        maxv;
      logic [63:0]        v;
      logic               f;
      int                 n;
      int                 mode;
      bit                 noisy;
      noisy = ($urandom_range(0, 4) == 0);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      mode = $urandom_range(0, 3);
      wsum = '0;
      for (int k = 0; k < n; k++) begin
         case (mode)
            0: w = $urandom_range(0, 15);
            1: w = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
            2: w = $urandom;
            default: w = $urandom_range(0, 1000);
         endcase
         wts.push_back(w);
         wsum += w;
      end
      case ($urandom_range(0, 7))
         0: lim = 0;
         1: lim = 1;
         2: lim = LIMIT_W'($urandom_range(2, 4));
         3: lim = LIMIT_W'($urandom_range(5, 16));
         4: lim = PART_LIMIT_RST;
         5: lim = MAX_PARTS;
         6: lim = LIMIT_W'($urandom_range(257, 511));
         default: lim = LIMIT_W'($urandom_range(0, 511));
      endcase
      case ($urandom_range(0, 9))
         0: total = '0;
         1: total = COUNT_SAT;
         2: total = COUNT_W'({$urandom, $urandom});
         3: total = wsum + $urandom_range(0, 9);
         default: total = wsum;
      endcase
      case ($urandom_range(0, 6))
         0: distinct = '0;
         1: distinct = COUNT_SAT;
         2: distinct = COUNT_W'({$urandom, $urandom});
         3: distinct = COUNT_W'(lim);
         4: distinct = COUNT_W'(lim) + COUNT_W'(1);
         default: distinct = COUNT_W'(n);
      endcase
      case ($urandom_range(0, 5))
         0: maxv = VAL_MIN;
         1: maxv = VAL_MAX;
         default: maxv = {$urandom, $urandom};
      endcase
      burst = ($urandom_range(0, 5) == 0);
      quiesce();
      write_reg(CSR_TOTAL_COUNT, {16'($urandom), total});
      write_reg(CSR_DISTINCT_COUNT, {16'($urandom), distinct});
      write_reg(CSR_PART_LIMIT, {55'({$urandom, $urandom}), lim});
      write_reg(CSR_MAX_VALUE, maxv);
      csr_bus.valid <= 1'b0;
      v = {$urandom, $urandom};
      for (int k = 0; k < n; k++) begin
         if (noisy) begin
            // scrambled values, stray run ends, possibly no end at all
            v = {$urandom, $urandom};
            w = ($urandom_range(0, 1) == 0) ? $urandom : wts[k];
            f = ($urandom_range(0, 7) == 0);
         end else begin
            v = v + $urandom_range(1, 50);
            w = wts[k];
            f = (k == n - 1);
         end
         drive_item(v, w, f, 1'b0, '0);
      end
      burst = 1'b0;
   endtask

   initial begin : stimulus
      int base;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.value      <= '0;
      req_bus.weight     <= '0;
      req_bus.final_item <= 1'b0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_TOTAL_COUNT;
      csr_bus.data       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: nothing closes on zero weight, anything else closes at once
      add_typed(64'd5, 32'd0, 1'b1, make_bucket('0, '0, '0, 1'b1, 1'b1));
      add_typed(-64'sd3, 32'd7, 1'b1, make_bucket(-64'sd3, -64'sd3, 48'd7, 1'b1, 1'b0));
      add_item(VAL_MIN, 32'd1, 1'b0);
      add_item(VAL_MAX, '1, 1'b1);
      // two buckets reach the limit, the rest of the run is dropped
      add_reg(CSR_PART_LIMIT, 64'd2);
      add_reg(CSR_DISTINCT_COUNT, 64'd100);
      add_reg(CSR_TOTAL_COUNT, 64'd10);
      add_reg(CSR_MAX_VALUE, VAL_MAX);
      add_item(64'd1, 32'd3, 1'b0);
      add_item(64'd2, 32'd2, 1'b0);
      add_item(64'd3, 32'd6, 1'b0);
      add_item(64'd4, 32'd9, 1'b0);
      add_item(64'd5, 32'd1, 1'b1);
      // open tail bucket at the end of the run
      add_reg(CSR_TOTAL_COUNT, 64'd100);
      add_item(64'd10, 32'd30, 1'b0);
      add_item(64'd11, 32'd30, 1'b0);
      add_item(64'd12, 32'd5, 1'b1);
      // bucket limit of zero clamps to one
      add_reg(CSR_PART_LIMIT, 64'd0);
      add_item(-64'sd1, 32'd50, 1'b0);
      add_item(64'd0, 32'd50, 1'b1);
      // bucket limit above the maximum clamps to the maximum
      add_reg(CSR_PART_LIMIT, 64'd511);
      add_reg(CSR_TOTAL_COUNT, 64'd0);
      add_item(64'd20, 32'd0, 1'b0);
      add_typed(64'd21, 32'd0, 1'b1, make_bucket('0, '0, '0, 1'b1, 1'b1));
      // settings change in the middle of a run
      add_item(64'd30, 32'd4, 1'b0);
      add_reg(CSR_DISTINCT_COUNT, '1);
      add_reg(CSR_TOTAL_COUNT, 64'd1000);
      add_item(64'd31, 32'd3, 1'b0);
      add_item(64'd32, 32'd1, 1'b1);
      // zero target depth closes even an empty-weight item
      add_reg(CSR_MAX_VALUE, VAL_MIN);
      add_reg(CSR_PART_LIMIT, 64'd1);
      add_reg(CSR_TOTAL_COUNT, 64'd0);
      add_typed(64'd40, 32'd0, 1'b1, make_bucket(64'd40, VAL_MIN, '0, 1'b1, 1'b0));
      play_script();

      saturation_sweep();

      base = taken_items;
      while (taken_items - base < RANDOM_ITEMS) run_phase();

      req_bus.valid <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < DRAIN_LIMIT && expected_buckets.size() != 0; k++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_buckets.size() != 0)
         report_mismatch($sformatf("%0d buckets never emitted", expected_buckets.size()));
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
